>>> rtl/core/bez_pkg.sv
package bez_pkg;

    localparam int DEFAULT_MAX_DEGREE = 12;
    localparam int TABLE_DEGREE       = 12;

    localparam int Q_W     = 17;
    localparam int COORD_W = 32;
    localparam int ALPHA_W = 26;
    localparam int BINOM_W = 10;
    localparam int MUL_A_W = 28;
    localparam int MUL_B_W = 33;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = 48;

    localparam logic [Q_W-1:0] ONE_Q16 = 17'h10000;

    typedef logic [Q_W-1:0] q16_t;
    typedef logic signed [COORD_W-1:0] coord_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_POW_T,
        ST_POW_U,
        ST_POW_WB,
        ST_WEIGHT,
        ST_ALPHA,
        ST_TERM_X,
        ST_TERM_Y,
        ST_ACC_Y,
        ST_FINISH
    } bez_state_t;

    typedef logic [BINOM_W-1:0] binom_row_t [TABLE_DEGREE+1];

    localparam binom_row_t BINOM [TABLE_DEGREE+1] = '{
        '{10'd1, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0,
          10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0},
        '{10'd1, 10'd1, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0,
          10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0},
        '{10'd1, 10'd2, 10'd1, 10'd0, 10'd0, 10'd0, 10'd0,
          10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0},
        '{10'd1, 10'd3, 10'd3, 10'd1, 10'd0, 10'd0, 10'd0,
          10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0},
        '{10'd1, 10'd4, 10'd6, 10'd4, 10'd1, 10'd0, 10'd0,
          10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0},
        '{10'd1, 10'd5, 10'd10, 10'd10, 10'd5, 10'd1, 10'd0,
          10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0},
        '{10'd1, 10'd6, 10'd15, 10'd20, 10'd15, 10'd6, 10'd1,
          10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0},
        '{10'd1, 10'd7, 10'd21, 10'd35, 10'd35, 10'd21, 10'd7,
          10'd1, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0},
        '{10'd1, 10'd8, 10'd28, 10'd56, 10'd70, 10'd56, 10'd28,
          10'd8, 10'd1, 10'd0, 10'd0, 10'd0, 10'd0},
        '{10'd1, 10'd9, 10'd36, 10'd84, 10'd126, 10'd126, 10'd84,
          10'd36, 10'd9, 10'd1, 10'd0, 10'd0, 10'd0},
        '{10'd1, 10'd10, 10'd45, 10'd120, 10'd210, 10'd252, 10'd210,
          10'd120, 10'd45, 10'd10, 10'd1, 10'd0, 10'd0},
        '{10'd1, 10'd11, 10'd55, 10'd165, 10'd330, 10'd462, 10'd462,
          10'd330, 10'd165, 10'd55, 10'd11, 10'd1, 10'd0},
        '{10'd1, 10'd12, 10'd66, 10'd220, 10'd495, 10'd792, 10'd924,
          10'd792, 10'd495, 10'd220, 10'd66, 10'd12, 10'd1}
    };

endpackage

>>> rtl/core/bezier_point_evaluator.sv
// channel  | signals                                              | transfer when
// ---------+------------------------------------------------------+---------------------
// input    | in_valid in_ready req_type point_index point_x       | in_valid & in_ready
//          | point_y t_value                                      |
// output   | out_valid out_ready curve_x curve_y                  | out_valid & out_ready
// config   | cfg_wr_en cfg_wr_data (curve_degree)                 | cfg_wr_en
//
// a load writes the point store at its transfer; an evaluate steps the single shared multiplier
// through POW_T, POW_U and POW_WB per power step, then WEIGHT to ACC_Y per Bernstein term
// reset clears the sequencer and output valid and sets the degree to 3; the point store is not cleared
// in_ready is high only in idle; a finished result waits in the output register, and the
// sequencer holds in its last state while a previous result has not yet been taken
module bezier_point_evaluator #(
    parameter int MAX_DEGREE = bez_pkg::DEFAULT_MAX_DEGREE
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [3:0]                        cfg_wr_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              req_type,
    input  logic [3:0]                        point_index,
    input  logic signed [31:0]                point_x,
    input  logic signed [31:0]                point_y,
    input  logic [16:0]                       t_value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [31:0]                curve_x,
    output logic signed [31:0]                curve_y
);

    localparam int DEPTH = MAX_DEGREE + 1;
    localparam int IW    = $clog2(DEPTH);

    bez_pkg::bez_state_t state_reg, state_next;
    logic [3:0]          degree_reg;
    logic [IW-1:0]       cnt_reg, cnt_next;
    logic [IW-1:0]       n_reg, n_next;
    logic                out_valid_reg, out_valid_next;

    bez_pkg::q16_t       t_reg, t_next;
    bez_pkg::q16_t       u_reg, u_next;
    bez_pkg::q16_t       tp_reg [DEPTH];
    bez_pkg::q16_t       tp_next [DEPTH];
    bez_pkg::q16_t       up_reg [DEPTH];
    bez_pkg::q16_t       up_next [DEPTH];
    logic [bez_pkg::ALPHA_W-1:0]      alpha_reg, alpha_next;
    logic signed [bez_pkg::ACC_W-1:0] acc_x_reg, acc_x_next;
    logic signed [bez_pkg::ACC_W-1:0] acc_y_reg, acc_y_next;
    bez_pkg::coord_t     curve_x_reg, curve_x_next;
    bez_pkg::coord_t     curve_y_reg, curve_y_next;

    bez_pkg::coord_t     store_x [DEPTH];
    bez_pkg::coord_t     store_y [DEPTH];
    bez_pkg::coord_t     store_rd_x_reg;
    bez_pkg::coord_t     store_rd_y_reg;

    logic signed [bez_pkg::MUL_A_W-1:0] mul_a;
    logic signed [bez_pkg::MUL_B_W-1:0] mul_b;
    logic signed [bez_pkg::MUL_P_W-1:0] prod_reg;

    logic [IW-1:0]       n_eff;
    bez_pkg::q16_t       t_clamp;
    bez_pkg::q16_t       prod_q16;
    logic signed [bez_pkg::ACC_W-1:0] term;
    logic                in_xfer;

    function automatic bez_pkg::coord_t sat32(input logic signed [bez_pkg::ACC_W-1:0] v);
        logic hi_zero;
        logic hi_ones;
        hi_zero = ~|v[bez_pkg::ACC_W-1:31];
        hi_ones = &v[bez_pkg::ACC_W-1:31];
        priority if (hi_zero || hi_ones)
            sat32 = v[31:0];
        else if (v[bez_pkg::ACC_W-1])
            sat32 = 32'h8000_0000;
        else
            sat32 = 32'h7fff_ffff;
    endfunction

    bez_mul u_mul (
        .clk      (clk),
        .mul_a    (mul_a),
        .mul_b    (mul_b),
        .prod_reg (prod_reg)
    );

    assign in_ready  = (state_reg == bez_pkg::ST_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign curve_x   = curve_x_reg;
    assign curve_y   = curve_y_reg;
    assign prod_q16  = prod_reg[32:16];
    assign term      = bez_pkg::ACC_W'(prod_reg >>> 16);

    always_comb
    begin
        priority if (degree_reg == 4'd0)
            n_eff = IW'(1);
        else if (degree_reg > 4'(MAX_DEGREE))
            n_eff = IW'(MAX_DEGREE);
        else
            n_eff = degree_reg[IW-1:0];
    end

    assign t_clamp = (t_value > bez_pkg::ONE_Q16) ? bez_pkg::ONE_Q16 : t_value;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        n_next         = n_reg;
        out_valid_next = out_valid_reg;
        t_next         = t_reg;
        u_next         = u_reg;
        tp_next        = tp_reg;
        up_next        = up_reg;
        alpha_next     = alpha_reg;
        acc_x_next     = acc_x_reg;
        acc_y_next     = acc_y_reg;
        curve_x_next   = curve_x_reg;
        curve_y_next   = curve_y_reg;
        mul_a          = '0;
        mul_b          = '0;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            bez_pkg::ST_IDLE:
            begin
                if (in_xfer && req_type)
                begin
                    t_next     = t_clamp;
                    u_next     = bez_pkg::ONE_Q16 - t_clamp;
                    n_next     = n_eff;
                    tp_next[0] = bez_pkg::ONE_Q16;
                    up_next[0] = bez_pkg::ONE_Q16;
                    cnt_next   = IW'(1);
                    state_next = bez_pkg::ST_POW_T;
                end
            end
            bez_pkg::ST_POW_T:
            begin
                mul_a      = bez_pkg::MUL_A_W'(tp_reg[cnt_reg - IW'(1)]);
                mul_b      = bez_pkg::MUL_B_W'(t_reg);
                state_next = bez_pkg::ST_POW_U;
            end
            bez_pkg::ST_POW_U:
            begin
                tp_next[cnt_reg] = prod_q16;
                mul_a      = bez_pkg::MUL_A_W'(up_reg[cnt_reg - IW'(1)]);
                mul_b      = bez_pkg::MUL_B_W'(u_reg);
                state_next = bez_pkg::ST_POW_WB;
            end
            bez_pkg::ST_POW_WB:
            begin
                up_next[cnt_reg] = prod_q16;
                if (cnt_reg == n_reg)
                begin
                    cnt_next   = '0;
                    acc_x_next = '0;
                    acc_y_next = '0;
                    state_next = bez_pkg::ST_WEIGHT;
                end
                else
                begin
                    cnt_next   = cnt_reg + IW'(1);
                    state_next = bez_pkg::ST_POW_T;
                end
            end
            bez_pkg::ST_WEIGHT:
            begin
                mul_a      = bez_pkg::MUL_A_W'(tp_reg[cnt_reg]);
                mul_b      = bez_pkg::MUL_B_W'(up_reg[n_reg - cnt_reg]);
                state_next = bez_pkg::ST_ALPHA;
            end
            bez_pkg::ST_ALPHA:
            begin
                mul_a      = bez_pkg::MUL_A_W'(bez_pkg::BINOM[4'(n_reg)][4'(cnt_reg)]);
                mul_b      = bez_pkg::MUL_B_W'(prod_q16);
                state_next = bez_pkg::ST_TERM_X;
            end
            bez_pkg::ST_TERM_X:
            begin
                alpha_next = prod_reg[bez_pkg::ALPHA_W-1:0];
                mul_a      = bez_pkg::MUL_A_W'(prod_reg[bez_pkg::ALPHA_W-1:0]);
                mul_b      = bez_pkg::MUL_B_W'(store_rd_x_reg);
                state_next = bez_pkg::ST_TERM_Y;
            end
            bez_pkg::ST_TERM_Y:
            begin
                acc_x_next = acc_x_reg + term;
                mul_a      = bez_pkg::MUL_A_W'(alpha_reg);
                mul_b      = bez_pkg::MUL_B_W'(store_rd_y_reg);
                state_next = bez_pkg::ST_ACC_Y;
            end
            bez_pkg::ST_ACC_Y:
            begin
                acc_y_next = acc_y_reg + term;
                if (cnt_reg == n_reg)
                    state_next = bez_pkg::ST_FINISH;
                else
                begin
                    cnt_next   = cnt_reg + IW'(1);
                    state_next = bez_pkg::ST_WEIGHT;
                end
            end
            bez_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    curve_x_next   = sat32(acc_x_reg);
                    curve_y_next   = sat32(acc_y_reg);
                    out_valid_next = 1'b1;
                    state_next     = bez_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bez_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bez_pkg::ST_IDLE;
            degree_reg    <= 4'd3;
            cnt_reg       <= '0;
            n_reg         <= IW'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            n_reg         <= n_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
                degree_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg       <= t_next;
        u_reg       <= u_next;
        tp_reg      <= tp_next;
        up_reg      <= up_next;
        alpha_reg   <= alpha_next;
        acc_x_reg   <= acc_x_next;
        acc_y_reg   <= acc_y_next;
        curve_x_reg <= curve_x_next;
        curve_y_reg <= curve_y_next;
    end

    // point store
    always_ff @(posedge clk)
    begin
        if (in_xfer && !req_type && (point_index <= 4'(MAX_DEGREE)))
        begin
            store_x[point_index[IW-1:0]] <= point_x;
            store_y[point_index[IW-1:0]] <= point_y;
        end
        store_rd_x_reg <= store_x[cnt_reg];
        store_rd_y_reg <= store_y[cnt_reg];
    end

endmodule

>>> rtl/core/bez_mul.sv
module bez_mul (
    input  logic                                   clk,
    input  logic signed [bez_pkg::MUL_A_W-1:0]     mul_a,
    input  logic signed [bez_pkg::MUL_B_W-1:0]     mul_b,
    output logic signed [bez_pkg::MUL_P_W-1:0]     prod_reg
);

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

endmodule

>>> bench/testbench.sv
module testbench;

    localparam int MAX_DEG         = bez_pkg::DEFAULT_MAX_DEGREE;
    localparam logic REQ_LOAD      = 1'b0;
    localparam logic REQ_EVAL      = 1'b1;
    localparam int DIRECTED_ROWS   = 24;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 230;
    localparam int SETTLE_CYCLES   = 8 * MAX_DEG + 7 + 8;
    localparam int RX_HOLD_CYCLES  = 400;
    localparam int MAX_REPORTS     = 10;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct packed {
        logic        req;
        logic [3:0]  idx;
        logic [31:0] x;
        logic [31:0] y;
        logic [16:0] t;
        logic        typed;
        logic [31:0] ex;
        logic [31:0] ey;
    } stim_row_t;

    typedef struct packed {
        bez_pkg::coord_t x;
        bez_pkg::coord_t y;
    } curve_point_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [3:0]         cfg_wr_data;
    logic               in_valid;
    logic               in_ready;
    logic               req_type;
    logic [3:0]         point_index;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [16:0]        t_value;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] curve_x;
    logic signed [31:0] curve_y;

    logic [3:0]        degree_reg;
    bez_pkg::coord_t   store_px [0:MAX_DEG];
    bez_pkg::coord_t   store_py [0:MAX_DEG];
    curve_point_t      pending_points [$];
    idle_mode_t        idle_mode;
    int                mismatch_count;
    int                hold_asked;
    int                hold_served;
    stim_row_t         directed_rows [DIRECTED_ROWS];

    bezier_point_evaluator dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .point_index (point_index),
        .point_x     (point_x),
        .point_y     (point_y),
        .t_value     (t_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .curve_x     (curve_x),
        .curve_y     (curve_y)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    initial
    begin
        #12000000;
        $display("testbench NOT OK");
        $finish;
    end

    function automatic bez_pkg::coord_t saturate_coord(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return bez_pkg::coord_t'(v[31:0]);
    endfunction

    // bernstein sum over the stored points at the current degree
    function automatic curve_point_t eval_curve(input logic [16:0] t_in);
        curve_point_t res;
        longint n;
        longint t;
        longint u;
        longint binom;
        longint w;
        longint alpha;
        longint sx;
        longint sy;
        longint tp [0:MAX_DEG];
        longint up [0:MAX_DEG];
        n = degree_reg;
        if (n < 1)
            n = 1;
        if (n > MAX_DEG)
            n = MAX_DEG;
        t = longint'(t_in);
        if (t > 65536)
            t = 65536;
        u = 65536 - t;
        tp[0] = 65536;
        up[0] = 65536;
        for (int i = 1; i <= n; i++)
        begin
            tp[i] = (tp[i - 1] * t) >>> 16;
            up[i] = (up[i - 1] * u) >>> 16;
        end
        binom = 1;
        sx = 0;
        sy = 0;
        for (int i = 0; i <= n; i++)
        begin
            w = (tp[i] * up[n - i]) >>> 16;
            alpha = binom * w;
            sx += (alpha * longint'(store_px[i])) >>> 16;
            sy += (alpha * longint'(store_py[i])) >>> 16;
            binom = binom * (n - i) / (i + 1);
        end
        res.x = saturate_coord(sx);
        res.y = saturate_coord(sy);
        return res;
    endfunction

    function automatic logic [31:0] random_coord();
        case ($urandom_range(19))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return 32'h00000000;
            3: return 32'hFFFFFFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic stim_row_t random_request();
        stim_row_t row;
        int pick;
        row = '0;
        row.x = random_coord();
        row.y = random_coord();
        row.idx = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 13))
                                           : 4'($urandom_range(MAX_DEG));
        pick = $urandom_range(19);
        if (pick < 2)
            row.t = 17'd0;
        else if (pick < 4)
            row.t = bez_pkg::ONE_Q16;
        else if (pick == 4)
            row.t = 17'($urandom_range(131071, 65537));
        else
            row.t = 17'($urandom_range(65536));
        row.req = ($urandom_range(99) < 55) ? REQ_EVAL : REQ_LOAD;
        return row;
    endfunction

    function automatic bit sender_idles();
        if (idle_mode == IDLE_SENDER)
            return $urandom_range(99) < 84;
        if (idle_mode == IDLE_BOTH)
            return $urandom_range(99) < 15;
        return 1'b0;
    endfunction

    // leaves valid high after the transfer so the next request can follow at once
    task automatic offer_request(input stim_row_t row);
        curve_point_t want;
        @(negedge clk);
        while (sender_idles())
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid    = 1'b1;
        req_type    = row.req;
        point_index = row.idx;
        point_x     = row.x;
        point_y     = row.y;
        t_value     = row.t;
        do
            @(posedge clk);
        while (!in_ready);
        if (row.req == REQ_LOAD)
        begin
            if (row.idx <= MAX_DEG)
            begin
                store_px[row.idx] = row.x;
                store_py[row.idx] = row.y;
            end
        end
        else
        begin
            if (row.typed)
            begin
                want.x = row.ex;
                want.y = row.ey;
            end
            else
                want = eval_curve(row.t);
            pending_points = {pending_points, want};
        end
    endtask

    task automatic release_input();
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic wait_results();
        while (pending_points.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_degree(input logic [3:0] value);
        @(negedge clk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
        degree_reg  = value;
    endtask

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch on %s: expected %h, got %h", what, want, got);
    endtask

    always @(posedge clk)
    begin
        curve_point_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_points.size() == 0)
                note_mismatch("unexpected transfer", 32'hx, curve_x);
            else
            begin
                want = pending_points.pop_front();
                if (curve_x !== want.x)
                    note_mismatch("curve_x", want.x, curve_x);
                if (curve_y !== want.y)
                    note_mismatch("curve_y", want.y, curve_y);
            end
        end
    end

    initial
    begin
        out_ready   = 1'b0;
        hold_served = 0;
        forever
        begin
            @(negedge clk);
            if (hold_asked != hold_served)
            begin
                hold_served = hold_asked;
                out_ready = 1'b0;
                repeat (RX_HOLD_CYCLES - 1)
                    @(negedge clk);
            end
            else if (idle_mode == IDLE_RECEIVER)
                out_ready = $urandom_range(99) >= 84;
            else if (idle_mode == IDLE_BOTH)
                out_ready = $urandom_range(99) >= 15;
            else
                out_ready = 1'b1;
        end
    end

    initial
    begin
        logic [3:0] phase_degree [PHASES];
        stim_row_t  row;

        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = 4'd0;
        in_valid       = 1'b0;
        req_type       = REQ_LOAD;
        point_index    = 4'd0;
        point_x        = 32'sd0;
        point_y        = 32'sd0;
        t_value        = 17'd0;
        idle_mode      = IDLE_NONE;
        mismatch_count = 0;
        hold_asked     = 0;
        degree_reg     = 4'd3;
        for (int i = 0; i <= MAX_DEG; i++)
        begin
            store_px[i] = 32'sd0;
            store_py[i] = 32'sd0;
        end

        // degree 3 from reset: t = 0 gives slot 0, t >= 1.0 gives slot 3
        directed_rows = '{
            '{REQ_LOAD, 4'd0,  32'h7FFFFFFF, 32'h80000000, 17'd0, 1'b0, 32'h0, 32'h0},
            '{REQ_LOAD, 4'd1,  32'h80000000, 32'h7FFFFFFF, 17'd0, 1'b0, 32'h0, 32'h0},
            '{REQ_LOAD, 4'd2,  32'hFFFFFFFF, 32'h00000000, 17'd0, 1'b0, 32'h0, 32'h0},
            '{REQ_LOAD, 4'd3,  32'h00010000, 32'hFFFF0000, 17'd0, 1'b0, 32'h0, 32'h0},
            '{REQ_LOAD, 4'd4,  32'h12345678, 32'hEDCBA988, 17'd0, 1'b0, 32'h0, 32'h0},
            '{REQ_LOAD, 4'd5,  32'h7FFFFFFF, 32'h7FFFFFFF, 17'd0, 1'b0, 32'h0, 32'h0},
            '{REQ_LOAD, 4'd6,  32'h80000000, 32'h80000000, 17'd0, 1'b0, 32'h0, 32'h0},
            '{REQ_LOAD, 4'd7,  32'h00000000, 32'hFFFFFFFF, 17'd0, 1'b0, 32'h0, 32'h0},
            '{REQ_LOAD, 4'd8,  32'h55555555, 32'hAAAAAAAA, 17'd0, 1'b0, 32'h0, 32'h0},
            '{REQ_LOAD, 4'd9,  32'hAAAAAAAA, 32'h55555555, 17'd0, 1'b0, 32'h0, 32'h0},
            '{REQ_LOAD, 4'd10, 32'h00008000, 32'hFFFF8000, 17'd0, 1'b0, 32'h0, 32'h0},
            '{REQ_LOAD, 4'd11, 32'h7FFF0000, 32'h80010000, 17'd0, 1'b0, 32'h0, 32'h0},
            '{REQ_LOAD, 4'd12, 32'h80000001, 32'h7FFFFFFE, 17'd0, 1'b0, 32'h0, 32'h0},
            '{REQ_LOAD, 4'd13, 32'hDEADBEEF, 32'hDEADBEEF, 17'd0, 1'b0, 32'h0, 32'h0},
            '{REQ_LOAD, 4'd14, 32'hCAFEF00D, 32'hCAFEF00D, 17'd0, 1'b0, 32'h0, 32'h0},
            '{REQ_LOAD, 4'd15, 32'hFFFFFFFF, 32'hFFFFFFFF, 17'd0, 1'b0, 32'h0, 32'h0},
            '{REQ_EVAL, 4'd0,  32'h0, 32'h0, 17'd0,      1'b1, 32'h7FFFFFFF, 32'h80000000},
            '{REQ_EVAL, 4'd15, 32'h0, 32'h0, 17'h10000,  1'b1, 32'h00010000, 32'hFFFF0000},
            '{REQ_EVAL, 4'd0,  32'h0, 32'h0, 17'h1FFFF,  1'b1, 32'h00010000, 32'hFFFF0000},
            '{REQ_EVAL, 4'd0,  32'h0, 32'h0, 17'h08000,  1'b0, 32'h0, 32'h0},
            '{REQ_EVAL, 4'd0,  32'h0, 32'h0, 17'h00001,  1'b0, 32'h0, 32'h0},
            '{REQ_EVAL, 4'd0,  32'h0, 32'h0, 17'h0FFFF,  1'b0, 32'h0, 32'h0},
            '{REQ_LOAD, 4'd0,  32'h00000001, 32'hFFFFFFFE, 17'd0, 1'b0, 32'h0, 32'h0},
            '{REQ_EVAL, 4'd0,  32'h0, 32'h0, 17'd0,      1'b1, 32'h00000001, 32'hFFFFFFFE}
        };

        phase_degree = '{4'd1, 4'd12, 4'd0, 4'd15, 4'd7, 4'd3, 4'd13, 4'($urandom_range(15))};

        repeat (4)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < DIRECTED_ROWS; i++)
            offer_request(directed_rows[i]);

        for (int p = 0; p < PHASES; p++)
        begin
            release_input();
            wait_results();
            repeat (SETTLE_CYCLES)
                @(posedge clk);
            write_degree(phase_degree[p]);
            idle_mode = idle_mode_t'(p % 4);
            // long receiver hold while requests keep coming
            if (p == 4)
                hold_asked++;
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                if (p == 1 && k % 16 == 15)
                begin
                    release_input();
                    wait_results();
                end
                row = random_request();
                offer_request(row);
            end
        end

        release_input();
        wait_results();
        repeat (SETTLE_CYCLES)
            @(posedge clk);

        if (mismatch_count == 0 && pending_points.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
